### rtl/tovg_pkg.sv
// Shared types, constants and the 5x8 glyph table for the text overlay pixel generator.
// Used by tovg_store, tovg_shade and text_overlay_pixel_generator; depends on nothing.

package tovg_pkg;

	localparam int DEF_SCREEN_WIDTH  = 184;
	localparam int DEF_SCREEN_HEIGHT = 96;

	localparam int CELL_W     = 6;
	localparam int GLYPH_W    = 5;
	localparam int GLYPH_H    = 8;
	localparam int LAST_GLYPH = 95;
	localparam logic [7:0] CODE_FIRST = 8'd32;

	typedef enum logic [1:0] {
		OP_WRITE_CHAR = 2'd0,
		OP_SET_COLORS = 2'd1,
		OP_QUERY      = 2'd2
	} op_t;

	// Write request from the decode stage into the stores
	typedef struct packed {
		logic        char_we;   // store code at the character address
		logic        col0;      // the write lands in column 0 of its line
		logic        color_we;  // store the color pair of the line
		logic [7:0]  code;
		logic [31:0] pair;      // fg in 31..16, bg in 15..0
	} wr_req_t;

	// Registered read data of the stores
	typedef struct packed {
		logic [7:0]  code;
		logic [31:0] pair;
		logic        nonblank;  // first byte of the line is not zero
	} rd_data_t;

	// One entry per glyph: column 0 in bits 39..32 through column 4 in bits 7..0;
	// bit r of a column byte is pixel row r.
	localparam logic [39:0] GLYPH_ROM [LAST_GLYPH + 1] = '{
		40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
		40'h3E7F637F3E, 40'h2313086462, 40'h0C3C3C3C0C, 40'h0008070300,
		40'h001C224100, 40'h0041221C00, 40'h2A1C7F1C2A, 40'h08083E0808,
		40'h0080703000, 40'h0808080808, 40'h0000606000, 40'h2010080402,
		40'h3E5149453E, 40'h00427F4000, 40'h7249494946, 40'h2141494D33,
		40'h1814127F10, 40'h2745454539, 40'h3C4A494931, 40'h4121110907,
		40'h3649494936, 40'h464949291E, 40'h0000140000, 40'h0040340000,
		40'h0008142241, 40'h1414141414, 40'h0041221408, 40'h0201590906,
		40'h3E415D594E, 40'h7C1211127C, 40'h7F49494936, 40'h3E41414122,
		40'h7F4141413E, 40'h7F49494941, 40'h7F09090901, 40'h3E41415173,
		40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
		40'h7F40404040, 40'h7F021C027F, 40'h7F0408107F, 40'h3E4141413E,
		40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h2649494932,
		40'h03017F0103, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
		40'h6314081463, 40'h0304780403, 40'h6159494D43, 40'h007F414141,
		40'h0204081020, 40'h004141417F, 40'h0402010204, 40'h4040404040,
		40'h0003070800, 40'h2054547840, 40'h7F28444438, 40'h3844444428,
		40'h384444287F, 40'h3854545418, 40'h00087E0902, 40'h18A4A49C78,
		40'h7F08040478, 40'h00447D4000, 40'h2040403D00, 40'h7F10284400,
		40'h00417F4000, 40'h7C04780478, 40'h7C08040478, 40'h3844444438,
		40'hFC18242418, 40'h18242418FC, 40'h7C08040408, 40'h4854545424,
		40'h04043F4424, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
		40'h4428102844, 40'h4C9090907C, 40'h4464544C44, 40'h0008364100,
		40'h0000770000, 40'h0041360800, 40'h0201020402, 40'h3C2623263C
	};

endpackage

### rtl/tovg_store.sv
// Character memory with its clearing sweep, line color registers and line blank flags.
// Depends on tovg_pkg for the request and read data structs.

module tovg_store #(
	parameter int SCREEN_WIDTH  = tovg_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = tovg_pkg::DEF_SCREEN_HEIGHT,
	localparam int CELLS = SCREEN_WIDTH / tovg_pkg::CELL_W,
	localparam int LINES = SCREEN_HEIGHT / tovg_pkg::GLYPH_H,
	localparam int DEPTH = LINES * CELLS,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int LNW   = (LINES > 1) ? $clog2(LINES) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tovg_pkg::wr_req_t  wr,
	input  logic [AW-1:0]      wr_addr,
	input  logic [LNW-1:0]     wr_line,
	input  logic               rd_en,
	input  logic [AW-1:0]      rd_addr,
	input  logic [LNW-1:0]     rd_line,
	output tovg_pkg::rd_data_t rd,
	output logic               clr_busy
);

	logic [7:0]       mem [DEPTH];
	logic [31:0]      color_q [LINES];
	logic [LINES-1:0] nonblank_q;
	logic             clr_busy_q;
	logic [AW-1:0]    clr_cnt_q;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [7:0]       mem_wdata;

	assign clr_busy  = clr_busy_q;
	assign mem_we    = clr_busy_q || wr.char_we;
	assign mem_waddr = clr_busy_q ? clr_cnt_q : wr_addr;
	assign mem_wdata = clr_busy_q ? 8'd0 : wr.code;

	// Zero sweep after reset, one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			if (clr_cnt_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rd.code     <= mem[rd_addr];
			rd.pair     <= color_q[rd_line];
			rd.nonblank <= nonblank_q[rd_line];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LINES; i++) begin
				color_q[i] <= '0;
			end
			nonblank_q <= '0;
		end else begin
			if (wr.color_we) begin
				color_q[wr_line] <= wr.pair;
			end
			if (wr.char_we && wr.col0) begin
				nonblank_q[wr_line] <= (wr.code != 8'd0);
			end
		end
	end

	a_clr_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !wr.char_we && !wr.color_we)
		else $error("store write during clearing sweep");

	a_clr_done: assert property (@(posedge clk) disable iff (!arst_n)
		(clr_busy_q && clr_cnt_q == AW'(DEPTH - 1)) |=> !clr_busy_q)
		else $error("clearing sweep overran the memory");

	a_clr_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(clr_busy_q && $past(clr_busy_q) && $past(arst_n))
			|-> clr_cnt_q == $past(clr_cnt_q) + 1'b1)
		else $error("clearing sweep skipped or stalled");

endmodule

### rtl/tovg_shade.sv
// Glyph lookup and color choice for one registered pixel query.
// Depends on tovg_pkg for the glyph table and the read data struct.

module tovg_shade (
	input  tovg_pkg::rd_data_t rd,
	input  logic               in_frame,   // a query inside the text area
	input  logic               cell_ok,    // inside a full cell, left of the gap column
	input  logic [2:0]         row,
	input  logic [2:0]         cx,
	output logic [15:0]        pixel_color,
	output logic               pixel_lit
);

	logic [7:0]  gidx;
	logic [6:0]  glyph;
	logic [39:0] entry;
	logic [7:0]  col_bits;

	always_comb begin
		gidx  = rd.code - tovg_pkg::CODE_FIRST;
		glyph = (gidx > 8'(tovg_pkg::LAST_GLYPH)) ? 7'(tovg_pkg::LAST_GLYPH) : gidx[6:0];
		entry = tovg_pkg::GLYPH_ROM[glyph];
		case (cx)
			3'd0:    col_bits = entry[39:32];
			3'd1:    col_bits = entry[31:24];
			3'd2:    col_bits = entry[23:16];
			3'd3:    col_bits = entry[15:8];
			3'd4:    col_bits = entry[7:0];
			default: col_bits = 8'd0;
		endcase
		pixel_lit   = in_frame && cell_ok && rd.nonblank && col_bits[row];
		pixel_color = !in_frame ? 16'd0 : (pixel_lit ? rd.pair[31:16] : rd.pair[15:0]);
	end

endmodule

### rtl/text_overlay_pixel_generator.sv
// Top level of the 5x8 text overlay pixel generator: input stage, decode, result stage.
// Depends on tovg_pkg, tovg_store and tovg_shade.
//
// Usage:
//   Input beats arrive on s_tvalid/s_tready with the operation in s_tuser: write a
//   character byte into a cell, set the fg/bg color pair of a text line, or query a
//   pixel. Every input beat yields exactly one output beat on m_tvalid/m_tready:
//   the pixel color and lit flag for a query, zeros for writes and unused codes.
//   The result passes through the input register, the registered read of the
//   character memory and line colors, and the result register before m_tvalid
//   rises. Throughput is one beat per cycle while m_tready stays high; the memory's
//   single read port serves one query per cycle.
//   After reset the character memory is swept to zero, one entry per cycle, for
//   (SCREEN_HEIGHT/8)*(SCREEN_WIDTH/6) entries (360 at the defaults); s_tready stays
//   low until the sweep ends. Line colors and blank flags clear at reset at once.
//   When the receiver stalls, each stage holds its beat; empty stages still fill,
//   and s_tready drops only once every stage is occupied.

module text_overlay_pixel_generator #(
	parameter int SCREEN_WIDTH  = tovg_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = tovg_pkg::DEF_SCREEN_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [3:0] line_index, [8:4] column_index, [16:9] char_code, [32:17] fg_color,
	// [48:33] bg_color, [56:49] pixel_x, [63:57] pixel_y
	input  logic [63:0] s_tdata,
	// [1:0] operation
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [15:0] pixel_color, [16] pixel_lit, [23:17] zero
	output logic [23:0] m_tdata
);

	localparam int CELLS = SCREEN_WIDTH / tovg_pkg::CELL_W;
	localparam int LINES = SCREEN_HEIGHT / tovg_pkg::GLYPH_H;
	localparam int DEPTH = LINES * CELLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LNW   = (LINES > 1) ? $clog2(LINES) : 1;

	// Stage 1: accepted beat
	logic        v1_q;
	logic [1:0]  op_s1;
	logic [3:0]  line_s1;
	logic [4:0]  col_s1;
	logic [7:0]  code_s1;
	logic [15:0] fg_s1;
	logic [15:0] bg_s1;
	logic [7:0]  px_s1;
	logic [6:0]  py_s1;

	// Stage 2: read data plus query side info
	logic        v2_q;
	logic        frame_s2;
	logic        cell_ok_s2;
	logic [2:0]  row_s2;
	logic [2:0]  cx_s2;

	// Stage 3: result register
	logic        mv_q;
	logic [15:0] color_s3;
	logic        lit_s3;

	logic en1, en2, en3;
	logic clr_busy;

	tovg_pkg::op_t      op;
	tovg_pkg::wr_req_t  wr;
	tovg_pkg::rd_data_t rd;

	logic [AW-1:0]  wr_addr;
	logic [LNW-1:0] wr_line;
	logic [AW-1:0]  rd_addr;
	logic [LNW-1:0] rd_line;
	logic           line_ok;
	logic           char_ok;
	logic           frame_ok;
	logic           qry_frame;
	logic [3:0]     q_line;
	logic [12:0]    div_prod;
	logic [5:0]     cell_idx;
	logic [7:0]     cx_full;
	logic           cell_ok;
	logic [15:0]    shade_color;
	logic           shade_lit;

	// Advance each stage when the one after it moves or is empty
	assign en3      = !mv_q || m_tready;
	assign en2      = !v2_q || en3;
	assign en1      = !v1_q || en2;
	assign s_tready = en1 && !clr_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			mv_q <= 1'b0;
		end else begin
			if (en1) begin
				v1_q <= s_tvalid && s_tready;
			end
			if (en2) begin
				v2_q <= v1_q;
			end
			if (en3) begin
				mv_q <= v2_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= s_tuser;
			line_s1 <= s_tdata[3:0];
			col_s1  <= s_tdata[8:4];
			code_s1 <= s_tdata[16:9];
			fg_s1   <= s_tdata[32:17];
			bg_s1   <= s_tdata[48:33];
			px_s1   <= s_tdata[56:49];
			py_s1   <= s_tdata[63:57];
		end
	end

	// Decode: cell = x/6 as ((x>>1)*43)>>7, exact for 8-bit x
	always_comb begin
		op       = tovg_pkg::op_t'(op_s1);
		line_ok  = 32'(line_s1) < LINES;
		char_ok  = line_ok && (32'(col_s1) < CELLS);
		frame_ok = (32'(px_s1) < SCREEN_WIDTH) && (32'(py_s1) < LINES * tovg_pkg::GLYPH_H);
		q_line   = py_s1[6:3];
		div_prod = 13'(px_s1[7:1]) * 13'd43;
		cell_idx = div_prod[12:7];
		cx_full  = px_s1 - 8'(cell_idx) * 8'd6;
		cell_ok  = (32'(cell_idx) < CELLS) && (cx_full < 8'(tovg_pkg::GLYPH_W));

		wr.char_we  = v1_q && en2 && (op == tovg_pkg::OP_WRITE_CHAR) && char_ok;
		wr.col0     = (col_s1 == 5'd0);
		wr.color_we = v1_q && en2 && (op == tovg_pkg::OP_SET_COLORS) && line_ok;
		wr.code     = code_s1;
		wr.pair     = {fg_s1, bg_s1};
		wr_addr     = AW'(32'(line_s1) * CELLS + 32'(col_s1));
		wr_line     = LNW'(line_s1);

		qry_frame = (op == tovg_pkg::OP_QUERY) && frame_ok;
		rd_addr   = qry_frame ? AW'(32'(q_line) * CELLS + 32'(cell_idx)) : '0;
		rd_line   = qry_frame ? LNW'(q_line) : '0;
	end

	tovg_store #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.wr_addr  (wr_addr),
		.wr_line  (wr_line),
		.rd_en    (en2),
		.rd_addr  (rd_addr),
		.rd_line  (rd_line),
		.rd       (rd),
		.clr_busy (clr_busy)
	);

	// Hold query info alongside the memory read
	always_ff @(posedge clk) begin
		if (en2) begin
			frame_s2   <= qry_frame;
			cell_ok_s2 <= cell_ok;
			row_s2     <= py_s1[2:0];
			cx_s2      <= cx_full[2:0];
		end
	end

	tovg_shade u_shade (
		.rd          (rd),
		.in_frame    (frame_s2),
		.cell_ok     (cell_ok_s2),
		.row         (row_s2),
		.cx          (cx_s2),
		.pixel_color (shade_color),
		.pixel_lit   (shade_lit)
	);

	always_ff @(posedge clk) begin
		if (en3) begin
			color_s3 <= shade_color;
			lit_s3   <= shade_lit;
		end
	end

	assign m_tvalid = mv_q;
	assign m_tdata  = {7'd0, lit_s3, color_s3};

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !s_tready)
		else $error("input accepted during clearing sweep");

	a_nonquery_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v2_q && en3 && !frame_s2) |=> (m_tdata == 24'd0))
		else $error("write or out-of-frame beat gave a nonzero result");

	a_lit_in_cell: assert property (@(posedge clk) disable iff (!arst_n)
		(v2_q && en3 && !cell_ok_s2) |=> !m_tdata[16])
		else $error("pixel lit outside the glyph columns");

endmodule

### verif/text_overlay_pixel_generator_test.sv
// Self-checking testbench for text_overlay_pixel_generator, the 5x8 text overlay.
// Sends character writes, line color sets and pixel queries, and predicts every result beat
// with its own model of the character store and font. Depends on tovg_pkg and the RTL only.

module text_overlay_pixel_generator_test;

	// Frame geometry at the default parameters: 12 text lines of 30 cells
	localparam int FRAME_W    = 184;
	localparam int FRAME_H    = 96;
	localparam int CELL_PIX   = 6;
	localparam int GLYPH_COLS = 5;
	localparam int GLYPH_ROWS = 8;
	localparam int CELLS      = FRAME_W / CELL_PIX;
	localparam int LINES      = FRAME_H / GLYPH_ROWS;

	localparam logic [7:0] CODE_BASE = 8'd32;
	localparam logic [7:0] TOP_GLYPH = 8'd95;
	localparam logic [1:0] OP_SPARE  = 2'd3;   // unused operation code

	localparam int STALL_PCT      = 26;
	localparam int WATCHDOG_LIMIT = 4000;   // covers the clearing sweep after reset
	localparam int DRAIN_CYCLES   = 12;

	// Font, one entry per glyph: column 0 in bits 39..32 down to column 4 in bits 7..0,
	// bit r of a column byte is pixel row r
	localparam logic [39:0] FONT_5X8 [96] = '{
		40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h3E7F637F3E,
		40'h2313086462, 40'h0C3C3C3C0C, 40'h0008070300, 40'h001C224100, 40'h0041221C00,
		40'h2A1C7F1C2A, 40'h08083E0808, 40'h0080703000, 40'h0808080808, 40'h0000606000,
		40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h7249494946, 40'h2141494D33,
		40'h1814127F10, 40'h2745454539, 40'h3C4A494931, 40'h4121110907, 40'h3649494936,
		40'h464949291E, 40'h0000140000, 40'h0040340000, 40'h0008142241, 40'h1414141414,
		40'h0041221408, 40'h0201590906, 40'h3E415D594E, 40'h7C1211127C, 40'h7F49494936,
		40'h3E41414122, 40'h7F4141413E, 40'h7F49494941, 40'h7F09090901, 40'h3E41415173,
		40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
		40'h7F021C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
		40'h7F09192946, 40'h2649494932, 40'h03017F0103, 40'h3F4040403F, 40'h1F2040201F,
		40'h3F4038403F, 40'h6314081463, 40'h0304780403, 40'h6159494D43, 40'h007F414141,
		40'h0204081020, 40'h004141417F, 40'h0402010204, 40'h4040404040, 40'h0003070800,
		40'h2054547840, 40'h7F28444438, 40'h3844444428, 40'h384444287F, 40'h3854545418,
		40'h00087E0902, 40'h18A4A49C78, 40'h7F08040478, 40'h00447D4000, 40'h2040403D00,
		40'h7F10284400, 40'h00417F4000, 40'h7C04780478, 40'h7C08040478, 40'h3844444438,
		40'hFC18242418, 40'h18242418FC, 40'h7C08040408, 40'h4854545424, 40'h04043F4424,
		40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h4C9090907C,
		40'h4464544C44, 40'h0008364100, 40'h0000770000, 40'h0041360800, 40'h0201020402,
		40'h3C2623263C
	};

	// Input beat fields, line_index in the lowest bits, exactly as s_tdata packs them
	typedef struct packed {
		logic [6:0]  py;
		logic [7:0]  px;
		logic [15:0] bg;
		logic [15:0] fg;
		logic [7:0]  code;
		logic [4:0]  col;
		logic [3:0]  line;
	} cmd_t;

	// Result beat fields as m_tdata packs them
	typedef struct packed {
		logic [6:0]  pad;
		logic        lit;
		logic [15:0] color;
	} pixel_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;

	// Predicted contents of the character memory and the per-line color pairs
	logic [7:0]  char_mem [LINES * CELLS];
	logic [31:0] line_pair [LINES];
	pixel_t      pending_pixels [$];
	pixel_t      want_pixel;

	int  fail_count   = 0;
	int  quiet_cycles = 0;
	logic steady      = 1'b0;   // high: neither side idles nor stalls

	text_overlay_pixel_generator #(
		.SCREEN_WIDTH (FRAME_W),
		.SCREEN_HEIGHT(FRAME_H)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Apply one accepted beat to the predicted state and return the pixel it yields.
	// Writes yield zeros; out-of-range writes and the spare code change nothing.
	function automatic pixel_t shade_pixel(logic [1:0] op, cmd_t c);
		pixel_t     r;
		int         ln;
		int         row;
		int         cell_no;
		int         cx;
		logic [7:0] glyph;
		logic [7:0] col_bits;
		logic [31:0] pair;
		r = '0;
		case (op)
		tovg_pkg::OP_WRITE_CHAR: begin
			if (c.line < LINES && c.col < CELLS)
				char_mem[c.line * CELLS + c.col] = c.code;
		end
		tovg_pkg::OP_SET_COLORS: begin
			if (c.line < LINES)
				line_pair[c.line] = {c.fg, c.bg};
		end
		tovg_pkg::OP_QUERY: begin
			// outside the frame the pixel stays zero
			if (c.px < FRAME_W && c.py < FRAME_H) begin
				ln      = c.py / GLYPH_ROWS;
				row     = c.py % GLYPH_ROWS;
				cell_no = c.px / CELL_PIX;
				cx      = c.px % CELL_PIX;
				pair    = line_pair[ln];
				// a zero first byte blanks the line; the sixth column is always blank
				if (cell_no < CELLS && cx < GLYPH_COLS && char_mem[ln * CELLS] != 8'd0) begin
					// codes below the base wrap around and land on the clamp
					glyph = char_mem[ln * CELLS + cell_no] - CODE_BASE;
					if (glyph > TOP_GLYPH)
						glyph = TOP_GLYPH;
					col_bits = FONT_5X8[glyph][8 * (GLYPH_COLS - 1 - cx) +: 8];
					r.lit = col_bits[row];
				end
				r.color = r.lit ? pair[31:16] : pair[15:0];
			end
		end
		default: ;
		endcase
		return r;
	endfunction

	// Offer one beat, idling first at random; record its expected pixel once accepted.
	// s_tvalid stays high after the beat so the next call can follow back to back.
	task automatic send_beat(logic [1:0] op, cmd_t c);
		while (!steady && $urandom_range(99) < STALL_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= c;
		do @(posedge clk); while (!s_tready);
		pending_pixels.push_back(shade_pixel(op, c));
	endtask

	// Fields a beat does not use carry random values, so stray decode shows up
	task automatic write_char(int line, int col, logic [7:0] code);
		cmd_t c;
		c = {$urandom, $urandom};
		c.line = 4'(line);
		c.col  = 5'(col);
		c.code = code;
		send_beat(tovg_pkg::OP_WRITE_CHAR, c);
	endtask

	task automatic set_colors(int line, logic [15:0] fg, logic [15:0] bg);
		cmd_t c;
		c = {$urandom, $urandom};
		c.line = 4'(line);
		c.fg   = fg;
		c.bg   = bg;
		send_beat(tovg_pkg::OP_SET_COLORS, c);
	endtask

	task automatic query(int x, int y);
		cmd_t c;
		c = {$urandom, $urandom};
		c.px = 8'(x);
		c.py = 7'(y);
		send_beat(tovg_pkg::OP_QUERY, c);
	endtask

	task automatic test_reset_state();
		// the store clears at reset: every line blank, colors zero
		query(FRAME_W - 1, FRAME_H - 1);
	endtask

	task automatic test_glyph_cases();
		set_colors(0, 16'hFFFF, 16'h0000);
		write_char(0, 0, 8'h41);            // 'A'
		query(0, 2);                        // lit stroke
		query(4, 0);                        // unlit corner
		query(5, 2);                        // sixth column of the cell
		write_char(0, 1, 8'h05);            // below the first printable code
		query(6, 2);
		write_char(0, 2, 8'h00);            // zero byte away from column 0
		query(13, 1);
		write_char(0, CELLS - 1, 8'hFF);    // above the font, clamped
		query((CELLS - 1) * CELL_PIX + 4, 5);
	endtask

	task automatic test_frame_edges();
		set_colors(LINES - 1, 16'hA5A5, 16'h5A5A);
		write_char(LINES - 1, 0, 8'h7E);
		query(0, FRAME_H - 7);              // bottom line, lit
		query(FRAME_W - 1, FRAME_H - 1);    // right of the last full cell
		query(FRAME_W, 0);                  // just outside, right
		query(255, 127);                    // field maxima
		query(0, FRAME_H);                  // just outside, below
	endtask

	task automatic test_ignored_writes();
		cmd_t c;
		write_char(LINES, 0, 8'h41);
		write_char(15, 31, 8'h00);
		write_char(0, CELLS, 8'h00);        // would blank line 1 if it wrapped
		set_colors(15, 16'h0000, 16'hFFFF);
		c = {$urandom, $urandom};
		send_beat(OP_SPARE, c);
		query(0, 2);                        // line 0 must be untouched
	endtask

	task automatic test_blank_line();
		write_char(0, 0, 8'h00);
		query(6, 2);                        // column 1 still holds a glyph, yet blank
	endtask

	// Give every line colors and a printable first byte so queries get past the blank check
	task automatic test_screen_fill();
		for (int ln = 0; ln < LINES; ln++) begin
			set_colors(ln, 16'($urandom), 16'($urandom));
			write_char(ln, 0, 8'($urandom_range(126, 33)));
		end
	endtask

	// Mostly well-formed writes and in-frame queries; a share of raw noise beats
	// with any operation code and any field values
	task automatic test_random_traffic(int count);
		cmd_t       c;
		logic [1:0] op;
		int         pick;
		repeat (count) begin
			c = {$urandom, $urandom};
			pick = $urandom_range(99);
			if (pick < 8) begin
				op = 2'($urandom_range(3));
			end else if (pick < 45) begin
				op = tovg_pkg::OP_WRITE_CHAR;
				c.line = 4'($urandom_range(LINES - 1));
				c.col  = ($urandom_range(4) == 0) ? 5'd0 : 5'($urandom_range(CELLS - 1));
				if ($urandom_range(9) < 7)
					c.code = 8'($urandom_range(127, 32));
				// blank a line now and then
				if (c.col == 0 && $urandom_range(19) == 0)
					c.code = 8'h00;
			end else if (pick < 55) begin
				op = tovg_pkg::OP_SET_COLORS;
				c.line = 4'($urandom_range(LINES - 1));
			end else begin
				op = tovg_pkg::OP_QUERY;
				c.px = 8'($urandom_range(FRAME_W - 1));
				c.py = 7'($urandom_range(FRAME_H - 1));
			end
			send_beat(op, c);
		end
	endtask

	// Same traffic with both sides always ready: beats every cycle through all stages
	task automatic test_back_to_back(int count);
		steady <= 1'b1;
		test_random_traffic(count);
		steady <= 1'b0;
	endtask

	// Sink side: stall at random and check each result beat against the oldest prediction
	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= STALL_PCT);
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t: result beat with nothing expected, got %h", $time, m_tdata);
				fail_count++;
			end else begin
				want_pixel = pending_pixels.pop_front();
				if (m_tdata[15:0] !== want_pixel.color) begin
					$display("%0t: pixel_color expected %h, got %h",
						$time, want_pixel.color, m_tdata[15:0]);
					fail_count++;
				end
				if (m_tdata[16] !== want_pixel.lit) begin
					$display("%0t: pixel_lit expected %b, got %b",
						$time, want_pixel.lit, m_tdata[16]);
					fail_count++;
				end
				if (m_tdata[23:17] !== want_pixel.pad) begin
					$display("%0t: padding expected %h, got %h",
						$time, want_pixel.pad, m_tdata[23:17]);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: end the run if no beat moves on either side for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: timeout, no beat for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		foreach (char_mem[i])
			char_mem[i] = 8'h00;
		foreach (line_pair[i])
			line_pair[i] = 32'h0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_glyph_cases();
		test_frame_edges();
		test_ignored_writes();
		test_blank_line();
		test_screen_fill();
		test_random_traffic(480);
		test_back_to_back(200);
		test_random_traffic(190);

		// drop valid, drain the outstanding results, then allow for stray beats
		s_tvalid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
